>>> design/ikx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikx_pkg: shared definitions for the index keystream XOR cipher
// Generator constants, the key character table and the stage payload type.
// ----------------------------------------------------------------------------
package ikx_pkg;

	// Linear congruential generator: state = state * LCG_MUL + LCG_ADD (mod 2^32).
	localparam logic [31:0] LCG_MUL = 32'd214013;
	localparam logic [31:0] LCG_ADD = 32'd2531011;

	// Width of the random value taken from bits 30..16 of the new state.
	localparam int unsigned RND_W = 15;
	localparam int unsigned RND_LSB = 16;

	// Key table length and the reciprocal used for the remainder by KEY_LEN.
	localparam int unsigned KEY_LEN = 46;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned KEY_RECIP = (1 << RECIP_SHIFT) / KEY_LEN;
	localparam int unsigned QUOT_W = RND_W + 11 - RECIP_SHIFT;

	// Key characters, first character in the most significant byte.
	localparam logic [KEY_LEN*8-1:0] KEY_STR = "1qaz2wsx3edc4rfv5tgb6yhn7ujm8ik,9ol.0p;/-@:^[]";

	// Payload of the stage that holds the generator output.
	typedef struct packed {
		logic             valid;
		logic [7:0]       data;
		logic [RND_W-1:0] rnd;
	} rnd_stage_t;

	// Key character at a table position; positions past the end give zero.
	function automatic logic [7:0] key_char(input logic [5:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (int'(idx) < KEY_LEN) begin
			ch = KEY_STR[8*(KEY_LEN-1-int'(idx)) +: 8];
		end
		return ch;
	endfunction

endpackage

>>> design/ikx_lcg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikx_lcg: keystream generator stage
// Holds the generator state, advances it once per item and registers the
// random value together with the data byte.
// ----------------------------------------------------------------------------
module ikx_lcg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed,
	input  logic                valid_s1,
	input  logic [7:0]          data_s1,
	input  logic                restart_s1,
	input  logic                en_s2,
	output ikx_pkg::rnd_stage_t stage_s2
);
	import ikx_pkg::*;

	logic [31:0] state_q;
	logic [31:0] base;
	logic [31:0] lcg_next;
	logic        step;

	// A restart loads the seed before the step.
	assign base     = restart_s1 ? seed : state_q;
	assign lcg_next = base * LCG_MUL + LCG_ADD;
	assign step     = valid_s1 && en_s2;

	// Generator state moves on only when an item leaves the input register;
	// the generator stage takes the byte and the random value with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			stage_s2 <= '0;
		end else begin
			if (step) begin
				state_q       <= lcg_next;
				stage_s2.data <= data_s1;
				stage_s2.rnd  <= lcg_next[RND_LSB +: RND_W];
			end
			if (en_s2) begin
				stage_s2.valid <= valid_s1;
			end
		end
	end

endmodule

>>> design/ikx_keysel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikx_keysel: key character selection and XOR
// Reduces the random value modulo the key length in two registered steps,
// looks up the key character and XORs it into the data byte.
// ----------------------------------------------------------------------------
module ikx_keysel (
	input  logic                clk,
	input  logic                arst_n,
	input  ikx_pkg::rnd_stage_t stage_s2,
	output logic                en_s3,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte
);
	import ikx_pkg::*;

	logic                     valid_s3;
	logic [7:0]               data_s3;
	logic [RND_W-1:0]         rnd_s3;
	logic [QUOT_W-1:0]        quot_s3;
	logic                     en_out;
	logic [RND_W+10:0]        prod;
	logic [RND_W-1:0]         quot_x_len;
	logic [RND_W-1:0]         rem_full;
	logic [6:0]               rem_low;
	logic [6:0]               rem_fix;
	logic [7:0]               key_byte;

	// Stage enables: a stage loads when it is empty or its content moves on.
	assign en_out = !out_valid || !out_stall;
	assign en_s3  = !valid_s3 || en_out;

	// Quotient estimate by reciprocal; it is the true quotient or one less.
	assign prod = {11'd0, stage_s2.rnd} * (RND_W+11)'(KEY_RECIP);

	// Remainder with one correction step, then the table lookup.
	assign quot_x_len = RND_W'({{(RND_W-QUOT_W){1'b0}}, quot_s3} * RND_W'(KEY_LEN));
	assign rem_full   = rnd_s3 - quot_x_len;
	assign rem_low    = rem_full[6:0];
	assign rem_fix    = (rem_low >= 7'(KEY_LEN)) ? rem_low - 7'(KEY_LEN) : rem_low;
	assign key_byte   = key_char(rem_fix[5:0]);

	// Valid flags of the quotient stage and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= stage_s2.valid;
			end
			if (en_out) begin
				out_valid <= valid_s3;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s3 && stage_s2.valid) begin
			data_s3 <= stage_s2.data;
			rnd_s3  <= stage_s2.rnd;
			quot_s3 <= prod[RECIP_SHIFT +: QUOT_W];
		end
		if (en_out && valid_s3) begin
			out_byte <= data_s3 ^ key_byte;
		end
	end

endmodule

>>> design/index_keystream_xor_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_keystream_xor_cipher: keystream XOR cipher, one byte per transfer
// An LCG keystream picks a key character for every byte; the byte is XORed
// with it. Enciphering and deciphering are the same operation.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   data_byte, restart
//   out       out_valid / out_stall out_byte
//   cfg       cfg_valid / cfg_ready cfg_data (key seed)
//
// One byte per cycle is taken when the output is not stalled; a byte passes
// through the input register, generator stage, quotient
// stage and result register in that order. The generator state update in the generator stage
// is the loop that fixes the rate. Reset clears all valid flags,
// the generator state and the seed. A stalled output fills the empty stages
// first, after which in_stall is raised. Configuration is never stalled.
// ----------------------------------------------------------------------------
module index_keystream_xor_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import ikx_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        restart_s1;
	logic [31:0] seed_q;
	logic        en_s1;
	logic        en_s2;
	logic        en_s3;
	rnd_stage_t  stage_s2;

	// Stage enables back from the output.
	assign en_s2     = !stage_s2.valid || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_stall  = !en_s1;
	assign cfg_ready = 1'b1;

	// Seed register and input valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	ikx_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.restart_s1(restart_s1),
		.en_s2     (en_s2),
		.stage_s2  (stage_s2)
	);

	ikx_keysel u_keysel (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.en_s3    (en_s3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte)
	);

endmodule

>>> design/ikx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikx_checker: port-level checks for the keystream XOR cipher
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module ikx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// The input is held off only when the output is full and stalled.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output can move");

	// Configuration transfers are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_byte))
		else $error("result changed under stall");

endmodule

bind index_keystream_xor_cipher ikx_checker u_ikx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte (out_byte),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
